>>> design/elsm_pkg.sv
package elsm_pkg;

    localparam int SECTOR_W   = 48;
    localparam int OFFSET_W   = 56;
    localparam int BYTES_W    = 32;
    localparam int SBO_W      = 9;
    localparam int SLOT_W     = 4;
    localparam int RESULT_CAP = 16;
    localparam int CAP_W      = 5;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_MAP   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_BEYOND   = 2'd2,
        ST_NOTHING  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_LCHK,
        S_LSUB,
        S_LADD,
        S_ACK,
        S_MINIT,
        S_MREM,
        S_RD,
        S_EV,
        S_FLUSH,
        S_PIECE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SECTOR_W-1:0] first;
        logic [SECTOR_W-1:0] len;
    } t_extent;

    typedef struct packed {
        logic capture;
        logic chk;
        logic sum_sub;
        logic sum_add;
        logic clear;
        logic ack;
        logic m_init;
        logic m_rem;
        logic ev;
        logic flush;
        logic piece;
        logic done;
    } t_dp_cmd;

    typedef struct packed {
        logic load_upd;
        logic walk_end;
        logic len_zero;
        logic hit;
        logic have_pend;
    } t_dp_sts;

endpackage

>>> design/elsm_if.sv
interface elsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  extent_slot;
    logic [47:0] start_sector;
    logic [47:0] sector_count;
    logic [55:0] file_offset;
    logic [31:0] byte_count;

    modport source(output valid, action, extent_slot, start_sector, sector_count,
                   file_offset, byte_count, input ready);
    modport sink(input valid, action, extent_slot, start_sector, sector_count,
                 file_offset, byte_count, output ready);
endinterface

interface elsm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [47:0] disk_sector;
    logic [8:0]  sector_byte_offset;
    logic [31:0] piece_bytes;
    logic        last;

    modport source(output valid, status, disk_sector, sector_byte_offset, piece_bytes,
                   last, input ready);
    modport sink(input valid, status, disk_sector, sector_byte_offset, piece_bytes,
                 last, output ready);
endinterface

>>> design/elsm_dp.sv
module elsm_dp #(
    parameter int MAX_EXTENTS  = 16,
    parameter int SECTOR_SHIFT = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  elsm_pkg::t_dp_cmd                   i_cmd,
    output elsm_pkg::t_dp_sts                   o_sts,
    input  logic [elsm_pkg::SECTOR_W-1:0]       i_disk_sectors,
    input  elsm_pkg::t_action                   i_action,
    input  logic [elsm_pkg::SLOT_W-1:0]         i_extent_slot,
    input  logic [elsm_pkg::SECTOR_W-1:0]       i_start_sector,
    input  logic [elsm_pkg::SECTOR_W-1:0]       i_sector_count,
    input  logic [elsm_pkg::OFFSET_W-1:0]       i_file_offset,
    input  logic [elsm_pkg::BYTES_W-1:0]        i_byte_count,
    output elsm_pkg::t_status                   o_status,
    output logic [elsm_pkg::SECTOR_W-1:0]       o_disk_sector,
    output logic [elsm_pkg::SBO_W-1:0]          o_sector_byte_offset,
    output logic [elsm_pkg::BYTES_W-1:0]        o_piece_bytes,
    output logic                                o_last
);
    import elsm_pkg::*;

    localparam int IDX_W   = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_EXTENTS + 1);
    localparam int RAW_W   = SECTOR_W + SECTOR_SHIFT + $clog2(MAX_EXTENTS + 1);
    localparam int SUM_W   = (RAW_W > 64) ? RAW_W : 65;
    localparam int NEED_W  = BYTES_W + 1 - SECTOR_SHIFT;
    localparam int PB_W    = BYTES_W + 1;

    t_extent                 r_mem [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0]  r_valid;
    t_extent                 r_rd;
    logic                    r_rd_valid;
    logic [SUM_W-1:0]        r_sum;

    t_action                 r_action;
    logic [SLOT_W-1:0]       r_slot;
    logic [SECTOR_W-1:0]     r_first;
    logic [SECTOR_W-1:0]     r_count;
    logic [OFFSET_W-1:0]     r_foff;
    logic [BYTES_W-1:0]      r_want;
    t_status                 r_code;

    logic                    r_past;
    logic [63:0]             r_diff;
    logic [BYTES_W-1:0]      r_remain;
    logic [SECTOR_W-1:0]     r_sector;
    logic [SECTOR_SHIFT-1:0] r_off;
    logic [CNT_W-1:0]        r_idx;
    logic [CAP_W-1:0]        r_n;
    logic [SECTOR_W-1:0]     r_avail;
    logic [SECTOR_W-1:0]     r_dsec;
    logic [NEED_W-1:0]       r_need;

    logic                    r_have_pend;
    logic [SECTOR_W-1:0]     r_pend_dsec;
    logic [SBO_W-1:0]        r_pend_sbo;
    logic [BYTES_W-1:0]      r_pend_bytes;

    t_status                 r_out_status;
    logic [SECTOR_W-1:0]     r_out_dsec;
    logic [SBO_W-1:0]        r_out_sbo;
    logic [BYTES_W-1:0]      r_out_bytes;
    logic                    r_out_last;

    logic [IDX_W-1:0]        n_raddr;
    logic                    n_slot_in;
    logic [SECTOR_W:0]       n_end;
    t_status                 n_code;
    logic [SUM_W-1:0]        n_old;
    logic [63:0]             n_tot;
    logic [64:0]             n_diff;
    logic [SECTOR_W-1:0]     n_len;
    logic [SECTOR_W:0]       n_avail;
    logic                    n_hit;
    logic [PB_W-1:0]         n_need_full;
    logic [PB_W-1:0]         n_short;
    logic [BYTES_W-1:0]      n_piece;

    always_comb begin
        n_slot_in   = (int'(r_slot) < MAX_EXTENTS);
        n_raddr     = (r_action == ACT_MAP) ? r_idx[IDX_W-1:0] : IDX_W'(r_slot);
        n_end       = {1'b0, r_first} + {1'b0, r_count};
        if (r_count == '0) begin
            n_code = ST_ZERO_LEN;
        end else if (n_end > {1'b0, i_disk_sectors}) begin
            n_code = ST_BEYOND;
        end else begin
            n_code = ST_OK;
        end
        n_old       = r_rd_valid ? (SUM_W'(r_rd.len) << SECTOR_SHIFT) : '0;
        n_tot       = (|r_sum[SUM_W-1:64]) ? '1 : r_sum[63:0];
        n_diff      = {1'b0, n_tot} - 65'(r_foff);
        n_len       = r_rd_valid ? r_rd.len : '0;
        n_avail     = {1'b0, n_len} - {1'b0, r_sector};
        n_hit       = !n_avail[SECTOR_W] && (n_avail != '0);
        n_need_full = ({1'b0, r_remain} + PB_W'(r_off) + PB_W'((1 << SECTOR_SHIFT) - 1))
                      >> SECTOR_SHIFT;
        n_short     = (PB_W'(r_avail[NEED_W-1:0]) << SECTOR_SHIFT) - PB_W'(r_off);
        n_piece     = (SECTOR_W'(r_need) > r_avail) ? n_short[BYTES_W-1:0] : r_remain;
    end

    assign o_sts.load_upd  = (r_code == ST_OK) && n_slot_in;
    assign o_sts.walk_end  = (r_idx == CNT_W'(MAX_EXTENTS)) || (r_remain == '0)
                             || (r_n == CAP_W'(RESULT_CAP));
    assign o_sts.len_zero  = (n_len == '0);
    assign o_sts.hit       = n_hit;
    assign o_sts.have_pend = r_have_pend;

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_add) begin
            r_mem[IDX_W'(r_slot)] <= '{first: r_first, len: r_count};
        end
        r_rd       <= r_mem[n_raddr];
        r_rd_valid <= r_valid[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_sum       <= '0;
            r_have_pend <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_sum   <= '0;
            end
            if (i_cmd.sum_sub) begin
                r_sum <= r_sum - n_old;
            end
            if (i_cmd.sum_add) begin
                r_sum                  <= r_sum + (SUM_W'(r_count) << SECTOR_SHIFT);
                r_valid[IDX_W'(r_slot)] <= 1'b1;
            end
            if (i_cmd.m_rem) begin
                r_have_pend <= 1'b0;
            end
            if (i_cmd.piece) begin
                r_have_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_slot   <= i_extent_slot;
            r_first  <= i_start_sector;
            r_count  <= i_sector_count;
            r_foff   <= i_file_offset;
            r_want   <= i_byte_count;
            r_sector <= SECTOR_W'(i_file_offset >> SECTOR_SHIFT);
            r_off    <= i_file_offset[SECTOR_SHIFT-1:0];
            r_code   <= (i_action == ACT_CLEAR) ? ST_OK : ST_NOTHING;
        end
        if (i_cmd.chk) begin
            r_code <= n_code;
        end
        if (i_cmd.m_init) begin
            r_past <= n_diff[64] || (n_diff == '0);
            r_diff <= n_diff[63:0];
        end
        if (i_cmd.m_rem) begin
            if (r_past) begin
                r_remain <= '0;
            end else if ({32'b0, r_want} > r_diff) begin
                r_remain <= r_diff[BYTES_W-1:0];
            end else begin
                r_remain <= r_want;
            end
            r_idx <= '0;
            r_n   <= '0;
        end
        if (i_cmd.ev) begin
            r_avail <= n_avail[SECTOR_W-1:0];
            r_dsec  <= r_rd.first + r_sector;
            r_need  <= NEED_W'(n_need_full);
            r_idx   <= r_idx + CNT_W'(1);
            if (!n_hit) begin
                r_sector <= r_sector - n_len;
            end
        end
        if (i_cmd.piece) begin
            r_pend_dsec  <= r_dsec;
            r_pend_sbo   <= SBO_W'(r_off);
            r_pend_bytes <= n_piece;
            r_remain     <= r_remain - n_piece;
            r_n          <= r_n + CAP_W'(1);
            r_sector     <= '0;
            r_off        <= '0;
        end

        // result register
        if (i_cmd.ack) begin
            r_out_status <= r_code;
            r_out_dsec   <= '0;
            r_out_sbo    <= '0;
            r_out_bytes  <= '0;
            r_out_last   <= 1'b1;
        end
        if (i_cmd.flush) begin
            r_out_status <= ST_OK;
            r_out_dsec   <= r_pend_dsec;
            r_out_sbo    <= r_pend_sbo;
            r_out_bytes  <= r_pend_bytes;
            r_out_last   <= 1'b0;
        end
        if (i_cmd.done) begin
            r_out_status <= r_have_pend ? ST_OK : ST_NOTHING;
            r_out_dsec   <= r_have_pend ? r_pend_dsec : '0;
            r_out_sbo    <= r_have_pend ? r_pend_sbo : '0;
            r_out_bytes  <= r_have_pend ? r_pend_bytes : '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_status             = r_out_status;
    assign o_disk_sector        = r_out_dsec;
    assign o_sector_byte_offset = r_out_sbo;
    assign o_piece_bytes        = r_out_bytes;
    assign o_last               = r_out_last;

endmodule

>>> design/elsm_ctrl.sv
module elsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  elsm_pkg::t_action i_action,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  elsm_pkg::t_dp_sts i_sts,
    output elsm_pkg::t_dp_cmd o_cmd
);
    import elsm_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    n_out_free;
    logic    n_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_out_free = !r_out_valid || i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_action)
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_LOAD:  n_state = S_LCHK;
                        ACT_MAP:   n_state = S_MINIT;
                        default:   n_state = S_ACK;
                    endcase
                end
            end
            S_CLEAR: begin
                if (n_out_free) begin
                    o_cmd.clear = 1'b1;
                    o_cmd.ack   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LCHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_LSUB;
            end
            S_LSUB: begin
                if (i_sts.load_upd) begin
                    o_cmd.sum_sub = 1'b1;
                    n_state       = S_LADD;
                end else begin
                    n_state = S_ACK;
                end
            end
            S_LADD: begin
                o_cmd.sum_add = 1'b1;
                n_state       = S_ACK;
            end
            S_ACK: begin
                if (n_out_free) begin
                    o_cmd.ack = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_MINIT: begin
                o_cmd.m_init = 1'b1;
                n_state      = S_MREM;
            end
            S_MREM: begin
                o_cmd.m_rem = 1'b1;
                n_state     = S_RD;
            end
            S_RD: begin
                n_state = i_sts.walk_end ? S_DONE : S_EV;
            end
            S_EV: begin
                o_cmd.ev = 1'b1;
                if (i_sts.len_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    n_state = i_sts.have_pend ? S_FLUSH : S_PIECE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                if (n_out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_PIECE;
                end
            end
            S_PIECE: begin
                o_cmd.piece = 1'b1;
                n_state     = S_RD;
            end
            S_DONE: begin
                if (n_out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_load  = o_cmd.ack || o_cmd.flush || o_cmd.done;
        n_out_valid = n_out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/extent_list_sector_mapper.sv
// Path from input transfer to result: clear via S_CLEAR, an unused action via S_ACK, a load
// via S_LCHK, S_LSUB, S_LADD (skipped when rejected) and S_ACK. A map sets up in S_MINIT and
// S_MREM, then walks the table one entry at a time (S_RD, S_EV); a hit emits a piece in
// S_PIECE, after flushing the pending one in S_FLUSH if any; a zero-length entry ends the
// list, and S_DONE finishes. The next item is taken in the cycle after the last result is
// registered. Reset empties the table, zeroes file size and disk_sectors, no result pending.
module extent_list_sector_mapper #(
    parameter int MAX_EXTENTS  = 16,
    parameter int SECTOR_SHIFT = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    elsm_in_if.sink      i_in,
    elsm_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import elsm_pkg::*;

    logic [SECTOR_W-1:0] r_disk_sectors;
    t_dp_cmd             cmd;
    t_dp_sts             sts;
    t_status             out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_sectors <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[3]) begin
            r_disk_sectors <= pwdata[SECTOR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? 64'b0 : {16'b0, r_disk_sectors};

    elsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_action    (t_action'(i_in.action)),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    elsm_dp #(
        .MAX_EXTENTS  (MAX_EXTENTS),
        .SECTOR_SHIFT (SECTOR_SHIFT)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_disk_sectors       (r_disk_sectors),
        .i_action             (t_action'(i_in.action)),
        .i_extent_slot        (i_in.extent_slot),
        .i_start_sector       (i_in.start_sector),
        .i_sector_count       (i_in.sector_count),
        .i_file_offset        (i_in.file_offset),
        .i_byte_count         (i_in.byte_count),
        .o_status             (out_status),
        .o_disk_sector        (o_out.disk_sector),
        .o_sector_byte_offset (o_out.sector_byte_offset),
        .o_piece_bytes        (o_out.piece_bytes),
        .o_last               (o_out.last)
    );

    assign o_out.status = out_status;

    // rejects and empty answers are always single results
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != ST_OK)) |-> o_out.last)
        else $error("non-ok result without last");

    // a piece followed by more pieces always moves data
    a_mid_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> ((o_out.piece_bytes != '0)
                                          && (o_out.status == ST_OK)))
        else $error("empty piece inside a request");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in work");

endmodule

>>> test/tb_extent_list_sector_mapper.sv
module tb_extent_list_sector_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import elsm_pkg::*;

    localparam int MAX_EXT         = 16;
    localparam int SEC_SHIFT       = 9;
    localparam int N_PHASE         = 12;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int IDLE_LIMIT      = 1000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int PRINT_CAP       = 50;
    localparam logic [3:0]  REG_DISK_SECTORS = 4'h0;
    localparam logic [63:0] ALL_ONES64       = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_action             act;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] start;
        logic [SECTOR_W-1:0] count;
        logic [OFFSET_W-1:0] foff;
        logic [BYTES_W-1:0]  nbytes;
    } t_item;

    typedef struct packed {
        t_status             st;
        logic [SECTOR_W-1:0] sector;
        logic [SBO_W-1:0]    sbo;
        logic [BYTES_W-1:0]  nbytes;
        logic                last;
    } t_piece;

    typedef enum logic {
        K_ITEM,
        K_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        t_action             act;
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] start;
        logic [SECTOR_W-1:0] count;
        logic [OFFSET_W-1:0] foff;
        logic [BYTES_W-1:0]  nbytes;
        logic                typed;
        t_status             st;
    } t_row;

    localparam int N_DIR = 26;

    // cfg rows carry the disk_sectors value in the start column
    t_row dir_tab [0:N_DIR-1] = '{
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd0, 32'd100, 1'b1, ST_NOTHING},
        '{K_ITEM, ACT_LOAD,  4'd0,  48'd0, 48'd1, 56'd0, 32'd0, 1'b1, ST_BEYOND},
        '{K_ITEM, ACT_LOAD,  4'd0,  48'd5, 48'd0, 56'd0, 32'd0, 1'b1, ST_ZERO_LEN},
        '{K_ITEM, ACT_NONE,  4'hF,  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
          56'hFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_NOTHING},
        '{K_CFG,  ACT_NONE,  4'd0,  48'hFFFF_FFFF_FFFF, 48'd0, 56'd0, 32'd0, 1'b0, ST_OK},
        '{K_ITEM, ACT_LOAD,  4'd0,  48'hFFFF_FFFF_FFFF, 48'd1, 56'd0, 32'd0, 1'b1, ST_BEYOND},
        '{K_ITEM, ACT_LOAD,  4'd0,  48'd0, 48'hFFFF_FFFF_FFFF, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'hFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd0, 32'd0, 1'b1, ST_NOTHING},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd1000, 32'd5000, 1'b0, ST_OK},
        '{K_ITEM, ACT_CLEAR, 4'd0,  48'd0, 48'd0, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd0, 32'd512, 1'b1, ST_NOTHING},
        '{K_ITEM, ACT_LOAD,  4'd0,  48'd100, 48'd1, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_LOAD,  4'd1,  48'd200, 48'd2, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_LOAD,  4'd2,  48'd300, 48'd3, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_LOAD,  4'd4,  48'd400, 48'd5, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd0, 32'hFFFF_FFFF, 1'b0, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd600, 32'd700, 1'b0, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd511, 32'd2, 1'b0, ST_OK},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd3072, 32'd100, 1'b1, ST_NOTHING},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd5632, 32'd100, 1'b1, ST_NOTHING},
        '{K_ITEM, ACT_LOAD,  4'd15, 48'd0, 48'd7, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_CFG,  ACT_NONE,  4'd0,  48'd10, 48'd0, 56'd0, 32'd0, 1'b0, ST_OK},
        '{K_ITEM, ACT_LOAD,  4'd3,  48'd5, 48'd5, 56'd0, 32'd0, 1'b1, ST_OK},
        '{K_ITEM, ACT_LOAD,  4'd5,  48'd6, 48'd5, 56'd0, 32'd0, 1'b1, ST_BEYOND},
        '{K_ITEM, ACT_MAP,   4'd0,  48'd0, 48'd0, 56'd0, 32'hFFFF_FFFF, 1'b0, ST_OK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    elsm_in_if  in_if ();
    elsm_out_if out_if ();

    extent_list_sector_mapper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's table and registers
    logic [SECTOR_W-1:0] tbl_first [MAX_EXT];
    logic [SECTOR_W-1:0] tbl_len   [MAX_EXT];
    logic [63:0]         shadow_bytes;
    logic [SECTOR_W-1:0] disk_limit;

    t_piece pred_q  [$];
    t_piece piece_q [$];

    int  n_mismatch = 0;
    int  n_items    = 0;
    int  n_results  = 0;
    int  n_pieces   = 0;
    int  n_cfg      = 0;
    int  idle_cnt   = 0;
    int  stall_left = 0;
    bit  no_idle    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 40);
    endfunction

    task automatic add_piece(input t_status st, input logic [63:0] sec,
                             input logic [63:0] off, input logic [63:0] nb, input logic last);
        t_piece pc;
        pc.st     = st;
        pc.sector = sec[SECTOR_W-1:0];
        pc.sbo    = off[SBO_W-1:0];
        pc.nbytes = nb[BYTES_W-1:0];
        pc.last   = last;
        pred_q.push_back(pc);
    endtask

    task automatic clear_table();
        for (int i = 0; i < MAX_EXT; i++) begin
            tbl_first[i] = '0;
            tbl_len[i]   = '0;
        end
        shadow_bytes = '0;
    endtask

    task automatic map_item(input t_item it);
        logic [63:0] sum, b, remain, sector, off, ln, avail, piece, foff;
        t_piece      pc;
        int          n;
        pred_q.delete();
        n = 0;
        case (it.act)
            ACT_CLEAR: begin
                clear_table();
                add_piece(ST_OK, 0, 0, 0, 1'b1);
            end
            ACT_LOAD: begin
                if (it.count == '0) begin
                    add_piece(ST_ZERO_LEN, 0, 0, 0, 1'b1);
                end else if ({1'b0, it.start} + {1'b0, it.count} > {1'b0, disk_limit}) begin
                    add_piece(ST_BEYOND, 0, 0, 0, 1'b1);
                end else begin
                    if (it.slot < MAX_EXT) begin
                        tbl_first[it.slot] = it.start;
                        tbl_len[it.slot]   = it.count;
                        sum = '0;
                        for (int i = 0; i < MAX_EXT; i++) begin
                            b = {16'b0, tbl_len[i]} << SEC_SHIFT;
                            if (sum > ALL_ONES64 - b)
                                sum = ALL_ONES64;
                            else
                                sum = sum + b;
                        end
                        shadow_bytes = sum;
                    end
                    add_piece(ST_OK, 0, 0, 0, 1'b1);
                end
            end
            ACT_MAP: begin
                foff = {8'b0, it.foff};
                if (foff >= shadow_bytes)
                    remain = '0;
                else if ({32'b0, it.nbytes} > shadow_bytes - foff)
                    remain = shadow_bytes - foff;
                else
                    remain = {32'b0, it.nbytes};
                sector = foff >> SEC_SHIFT;
                off    = foff & ((64'd1 << SEC_SHIFT) - 1);
                for (int i = 0; i < MAX_EXT && tbl_len[i] != '0 && remain != '0
                                && n < RESULT_CAP; i++) begin
                    ln = {16'b0, tbl_len[i]};
                    if (sector < ln) begin
                        piece = remain;
                        avail = ln - sector;
                        if (((piece + off + (64'd1 << SEC_SHIFT) - 1) >> SEC_SHIFT) > avail)
                            piece = (avail << SEC_SHIFT) - off;
                        add_piece(ST_OK, {16'b0, tbl_first[i]} + sector, off, piece, 1'b0);
                        n++;
                        remain = remain - piece;
                        sector = '0;
                        off    = '0;
                    end else begin
                        sector = sector - ln;
                    end
                end
                if (n == 0) begin
                    add_piece(ST_NOTHING, 0, 0, 0, 1'b1);
                end else begin
                    pc = pred_q.pop_back();
                    pc.last = 1'b1;
                    pred_q.push_back(pc);
                end
            end
            default: add_piece(ST_NOTHING, 0, 0, 0, 1'b1);
        endcase
    endtask

    task automatic xfer_item(input t_item it, input logic typed, input t_status st);
        int gap;
        gap = gap_len();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.action       <= it.act;
        in_if.extent_slot  <= it.slot;
        in_if.start_sector <= it.start;
        in_if.sector_count <= it.count;
        in_if.file_offset  <= it.foff;
        in_if.byte_count   <= it.nbytes;
        in_if.valid        <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        map_item(it);
        if (typed) begin
            pred_q.delete();
            add_piece(st, 0, 0, 0, 1'b1);
        end
        while (pred_q.size() != 0)
            piece_q.push_back(pred_q.pop_front());
        n_items++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (piece_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write disk_sectors, then read it back in a second APB transfer
    task automatic write_disk(input logic [SECTOR_W-1:0] value);
        logic [63:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DISK_SECTORS;
        pwdata  <= {16'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        disk_limit = value;
        n_cfg++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'b0, value})
            flag_mismatch("disk_sectors readback", rd, {16'b0, value});
    endtask

    function automatic t_item rand_item();
        t_item       it;
        logic [63:0] a, b, c;
        a = rnd64();
        b = rnd64();
        c = rnd64();
        it.act    = t_action'($urandom_range(0, 3));
        it.slot   = a[SLOT_W-1:0];
        it.start  = b[SECTOR_W-1:0];
        it.count  = c[SECTOR_W-1:0];
        it.foff   = OFFSET_W'(rnd64());
        it.nbytes = $urandom;
        return it;
    endfunction

    function automatic t_item rand_load(input int slot);
        t_item       it;
        logic [63:0] cnt, room, v;
        int          r;
        it      = rand_item();
        it.act  = ACT_LOAD;
        it.slot = slot[SLOT_W-1:0];
        r = $urandom_range(0, 99);
        if (r < 5) begin
            cnt = '0;
        end else if (r < 80) begin
            cnt = 64'($urandom_range(1, 40));
        end else if (r < 90) begin
            cnt = 64'($urandom_range(41, 5000));
        end else begin
            v   = rnd64();
            cnt = {16'b0, v[SECTOR_W-1:0]} >> $urandom_range(0, 47);
            if (cnt == '0)
                cnt = 64'd1;
        end
        it.count = cnt[SECTOR_W-1:0];
        r = $urandom_range(0, 99);
        if (cnt <= {16'b0, disk_limit}) begin
            room = {16'b0, disk_limit} - cnt;
            if (r < 80)
                v = rnd64() % (room + 1);
            else if (r < 90)
                v = room;
            else if (r < 95)
                v = room + 1;
            else
                v = rnd64();
            it.start = v[SECTOR_W-1:0];
        end
        return it;
    endfunction

    function automatic t_item rand_map();
        t_item       it;
        logic [63:0] acc, v, room;
        int          r, j;
        it     = rand_item();
        it.act = ACT_MAP;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            v = (shadow_bytes != '0) ? rnd64() % shadow_bytes : '0;
        end else if (r < 70) begin
            // land around an extent boundary
            j   = $urandom_range(0, MAX_EXT - 1);
            acc = '0;
            for (int i = 0; i < j; i++)
                acc = acc + ({16'b0, tbl_len[i]} << SEC_SHIFT);
            v = acc + 64'($urandom_range(0, 2));
            if (v != '0)
                v = v - 1;
        end else if (r < 80) begin
            v = (shadow_bytes != '0) ? shadow_bytes - 64'($urandom_range(0, 1)) : '0;
        end else begin
            v = rnd64();
        end
        it.foff = v[OFFSET_W-1:0];
        r = $urandom_range(0, 99);
        if (r < 40) begin
            it.nbytes = $urandom_range(1, 2048);
        end else if (r < 65) begin
            room = (shadow_bytes > {8'b0, it.foff}) ? shadow_bytes - {8'b0, it.foff} : '0;
            v = rnd64() % (room + 1024);
            it.nbytes = v[BYTES_W-1:0];
        end else if (r < 85) begin
            it.nbytes = $urandom;
        end else if (r < 92) begin
            it.nbytes = '0;
        end else begin
            it.nbytes = 32'hFFFF_FFFF;
        end
        return it;
    endfunction

    // result receiver with random backpressure
    always @(negedge i_clk) begin
        int len;
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            out_if.ready  <= 1'b0;
        end else begin
            len = gap_len();
            if (len > 0) begin
                stall_left   <= len - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_piece exp;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            n_results++;
            if (piece_q.size() == 0) begin
                flag_mismatch("result with nothing expected", {62'b0, out_if.status}, 64'd0);
            end else begin
                exp = piece_q.pop_front();
                if (exp.st == ST_OK && exp.nbytes != '0)
                    n_pieces++;
                if (out_if.status !== exp.st)
                    flag_mismatch("status", out_if.status, exp.st);
                if (out_if.disk_sector !== exp.sector)
                    flag_mismatch("disk_sector", out_if.disk_sector, exp.sector);
                if (out_if.sector_byte_offset !== exp.sbo)
                    flag_mismatch("sector_byte_offset", out_if.sector_byte_offset, exp.sbo);
                if (out_if.piece_bytes !== exp.nbytes)
                    flag_mismatch("piece_bytes", out_if.piece_bytes, exp.nbytes);
                if (out_if.last !== exp.last)
                    flag_mismatch("last", out_if.last, exp.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            idle_cnt = 0;
        else
            idle_cnt = idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, piece_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : main
        t_item       it;
        logic [63:0] v;
        logic [SECTOR_W-1:0] new_disk;
        int          nload, r;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_if.valid         = 1'b0;
        in_if.action        = ACT_CLEAR;
        in_if.extent_slot   = '0;
        in_if.start_sector  = '0;
        in_if.sector_count  = '0;
        in_if.file_offset   = '0;
        in_if.byte_count    = '0;
        out_if.ready        = 1'b0;
        clear_table();
        disk_limit = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++) begin
            if (dir_tab[k].kind == K_CFG) begin
                wait_idle();
                write_disk(dir_tab[k].start);
            end else begin
                it.act    = dir_tab[k].act;
                it.slot   = dir_tab[k].slot;
                it.start  = dir_tab[k].start;
                it.count  = dir_tab[k].count;
                it.foff   = dir_tab[k].foff;
                it.nbytes = dir_tab[k].nbytes;
                xfer_item(it, dir_tab[k].typed, dir_tab[k].st);
            end
        end

        for (int p = 0; p < N_PHASE; p++) begin
            wait_idle();
            v = rnd64();
            case (p % 6)
                0: new_disk = 48'hFFFF_FFFF_FFFF;
                1: new_disk = v[SECTOR_W-1:0];
                2: new_disk = SECTOR_W'($urandom_range(1000, 100000));
                3: new_disk = '0;
                4: new_disk = 48'd1;
                default: new_disk = {16'b0, v[31:0]};
            endcase
            write_disk(new_disk);
            no_idle = (p % 4 == 1);

            it     = rand_item();
            it.act = ACT_CLEAR;
            xfer_item(it, 1'b0, ST_OK);
            nload = $urandom_range(1, MAX_EXT);
            for (int k = 0; k < nload; k++)
                xfer_item(rand_load(k), 1'b0, ST_OK);
            for (int k = 0; k < ITEMS_PER_PHASE - 1 - nload; k++) begin
                r = $urandom_range(0, 99);
                if (r < 84) begin
                    it = rand_map();
                end else if (r < 92) begin
                    it = rand_load($urandom_range(0, MAX_EXT - 1));
                end else begin
                    it     = rand_item();
                    it.act = (r < 98) ? ACT_NONE : ACT_CLEAR;
                end
                xfer_item(it, 1'b0, ST_OK);
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items across %0d disk size settings; checked %0d results,",
                 n_items, n_cfg, n_results);
        $display("%0d of them nonempty mapped pieces; %0d mismatches.", n_pieces, n_mismatch);
        if (n_mismatch == 0 && piece_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
